>>> rtl/core/nad_pkg.sv
// nad_pkg: shared types and constants for the notification attribute deframer
// transaction structs, queue entry, parser phase codes and keep limit
// no dependencies
package nad_pkg;

    localparam int unsigned KEEP_LIMIT  = 511;
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [15:0] KEEP_LIMIT_W = 16'(KEEP_LIMIT);

    localparam logic [7:0] ATTR_APP_ID  = 8'd0;
    localparam logic [7:0] ATTR_MESSAGE = 8'd3;
    localparam logic [7:0] ATTR_TRACKED = 8'd4;

    localparam logic [3:0] MASK_APP_ID   = 4'h1;
    localparam logic [3:0] MASK_TITLE    = 4'h2;
    localparam logic [3:0] MASK_SUBTITLE = 4'h4;
    localparam logic [3:0] MASK_BODY     = 4'h8;

    localparam logic KIND_RESTART = 1'b0;

    typedef struct packed {
        logic        kind;
        logic [7:0]  data_byte;
        logic [31:0] request_uid;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  attr_id;
        logic [7:0]  attr_byte;
        logic        byte_kept;
        logic        empty_attribute;
        logic        last_of_attribute;
        logic        notification_done;
        logic [31:0] notif_uid;
        logic [3:0]  present_mask;
        logic [7:0]  command_id;
    } out_item_t;

    typedef enum logic [0:0] {
        OP_RESTART = 1'b0,
        OP_BYTE    = 1'b1
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [7:0]  data_byte;
        logic [31:0] uid;
    } queue_entry_t;

    typedef struct packed {
        logic         valid;
        queue_entry_t entry;
    } queue_head_t;

    typedef enum logic [8:0] {
        PH_CMD  = 9'b000000001,
        PH_UID0 = 9'b000000010,
        PH_UID1 = 9'b000000100,
        PH_UID2 = 9'b000001000,
        PH_UID3 = 9'b000010000,
        PH_ATTR = 9'b000100000,
        PH_LEN0 = 9'b001000000,
        PH_LEN1 = 9'b010000000,
        PH_DATA = 9'b100000000
    } phase_t;

    function automatic logic [3:0] attr_mask_bit(input logic [7:0] attr);
        logic [3:0] m;
        case (attr[1:0])
            2'd0:    m = MASK_APP_ID;
            2'd1:    m = MASK_TITLE;
            2'd2:    m = MASK_SUBTITLE;
            default: m = MASK_BODY;
        endcase
        if (attr >= ATTR_TRACKED)
        begin
            m = 4'h0;
        end
        return m;
    endfunction

endpackage

>>> rtl/core/nad_front.sv
// nad_front: accepts input transactions, classifies them and queues them
// for the parser
// depends on nad_pkg
module nad_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  nad_pkg::in_item_t  item,
    output nad_pkg::queue_head_t head,
    input  logic               head_pop
);

    nad_pkg::queue_entry_t           store [nad_pkg::QUEUE_DEPTH];
    logic [nad_pkg::QPTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [nad_pkg::QPTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [nad_pkg::QCNT_W-1:0]      count_reg, count_next;
    nad_pkg::queue_entry_t           classified;
    logic                            push;
    logic                            pop;

    // classify the transaction
    always_comb
    begin
        classified.op        = (item.kind == nad_pkg::KIND_RESTART) ?
                               nad_pkg::OP_RESTART : nad_pkg::OP_BYTE;
        classified.data_byte = item.data_byte;
        classified.uid       = item.request_uid;
    end

    assign item_ready = (count_reg != nad_pkg::QCNT_W'(nad_pkg::QUEUE_DEPTH));
    assign push       = item_valid && item_ready;
    assign pop        = head_pop && (count_reg != '0);

    assign head.valid = (count_reg != '0);
    assign head.entry = store[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == nad_pkg::QPTR_W'(nad_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == nad_pkg::QPTR_W'(nad_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store[wr_ptr_reg] <= classified;
        end
    end

endmodule

>>> rtl/core/nad_back.sv
// nad_back: response parser that consumes queued transactions and
// drives the registered result channel
// depends on nad_pkg
module nad_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  nad_pkg::queue_head_t head,
    output logic                 head_pop,
    output logic                 result_valid,
    input  logic                 result_ready,
    output nad_pkg::out_item_t   result
);

    nad_pkg::phase_t     phase_reg, phase_next;
    logic [7:0]          command_byte_reg, command_byte_next;
    logic [7:0]          current_attr_reg, current_attr_next;
    logic [15:0]         attr_length_reg, attr_length_next;
    logic [15:0]         bytes_read_reg, bytes_read_next;
    logic [31:0]         active_uid_reg, active_uid_next;
    logic [3:0]          seen_mask_reg, seen_mask_next;
    logic                res_valid_reg;
    nad_pkg::out_item_t  res_reg, res_next;
    logic                emit;
    logic [7:0]          b;
    logic [15:0]         len_full;
    logic [15:0]         br_inc;
    logic [3:0]          mask_done;
    logic                is_message;

    assign head_pop = head.valid && (!res_valid_reg || result_ready);
    assign b        = head.entry.data_byte;
    assign len_full = {b, attr_length_reg[7:0]};
    assign br_inc   = bytes_read_reg + 16'd1;
    assign mask_done  = seen_mask_reg | nad_pkg::attr_mask_bit(current_attr_reg);
    assign is_message = (current_attr_reg == nad_pkg::ATTR_MESSAGE);

    always_comb
    begin
        phase_next        = phase_reg;
        command_byte_next = command_byte_reg;
        current_attr_next = current_attr_reg;
        attr_length_next  = attr_length_reg;
        bytes_read_next   = bytes_read_reg;
        active_uid_next   = active_uid_reg;
        seen_mask_next    = seen_mask_reg;
        emit              = 1'b0;

        res_next.attr_id           = current_attr_reg;
        res_next.attr_byte         = b;
        res_next.byte_kept         = 1'b0;
        res_next.empty_attribute   = 1'b0;
        res_next.last_of_attribute = 1'b0;
        res_next.notification_done = 1'b0;
        res_next.notif_uid         = active_uid_reg;
        res_next.present_mask      = seen_mask_reg;
        res_next.command_id        = command_byte_reg;

        if (head.entry.op == nad_pkg::OP_RESTART)
        begin
            active_uid_next = head.entry.uid;
            seen_mask_next  = 4'h0;
            phase_next      = nad_pkg::PH_CMD;
        end
        else
        begin
            case (phase_reg)
                nad_pkg::PH_UID0: phase_next = nad_pkg::PH_UID1;
                nad_pkg::PH_UID1: phase_next = nad_pkg::PH_UID2;
                nad_pkg::PH_UID2: phase_next = nad_pkg::PH_UID3;
                nad_pkg::PH_UID3: phase_next = nad_pkg::PH_ATTR;
                nad_pkg::PH_ATTR:
                begin
                    current_attr_next = b;
                    phase_next        = nad_pkg::PH_LEN0;
                end
                nad_pkg::PH_LEN0:
                begin
                    attr_length_next = {8'h00, b};
                    phase_next       = nad_pkg::PH_LEN1;
                end
                nad_pkg::PH_LEN1:
                begin
                    attr_length_next = len_full;
                    bytes_read_next  = 16'd0;
                    if (len_full != 16'd0)
                    begin
                        phase_next = nad_pkg::PH_DATA;
                    end
                    else
                    begin
                        // empty attribute marker
                        seen_mask_next             = mask_done;
                        phase_next                 = nad_pkg::PH_ATTR;
                        emit                       = 1'b1;
                        res_next.attr_byte         = 8'h00;
                        res_next.empty_attribute   = 1'b1;
                        res_next.last_of_attribute = 1'b1;
                        res_next.notification_done = is_message;
                        res_next.present_mask      = mask_done;
                    end
                end
                nad_pkg::PH_DATA:
                begin
                    emit               = 1'b1;
                    bytes_read_next    = br_inc;
                    res_next.byte_kept = (bytes_read_reg < nad_pkg::KEEP_LIMIT_W);
                    if (br_inc >= attr_length_reg)
                    begin
                        seen_mask_next             = mask_done;
                        phase_next                 = nad_pkg::PH_ATTR;
                        res_next.last_of_attribute = 1'b1;
                        res_next.notification_done = is_message;
                        res_next.present_mask      = mask_done;
                    end
                end
                default:
                begin
                    command_byte_next = b;
                    phase_next        = nad_pkg::PH_UID0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= nad_pkg::PH_CMD;
            command_byte_reg <= 8'h00;
            current_attr_reg <= 8'h00;
            attr_length_reg  <= 16'h0000;
            bytes_read_reg   <= 16'h0000;
            active_uid_reg   <= 32'h0;
            seen_mask_reg    <= 4'h0;
            res_valid_reg    <= 1'b0;
        end
        else
        begin
            if (head_pop)
            begin
                phase_reg        <= phase_next;
                command_byte_reg <= command_byte_next;
                current_attr_reg <= current_attr_next;
                attr_length_reg  <= attr_length_next;
                bytes_read_reg   <= bytes_read_next;
                active_uid_reg   <= active_uid_next;
                seen_mask_reg    <= seen_mask_next;
            end
            if (head_pop && emit)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (head_pop && emit)
        begin
            res_reg <= res_next;
        end
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

endmodule

>>> rtl/core/notification_attribute_deframer.sv
// notification_attribute_deframer: top level joining the classifying front
// queue and the parser back end
// depends on nad_pkg, nad_front, nad_back
//
// byte-serial deframer for notification attribute responses. a restart
// transaction loads the request id and clears the presence mask; stream
// bytes then pass through command, id and attribute tuple parsing, and each
// attribute data byte (or one marker for an empty attribute) comes out as
// one result transaction. one transaction is accepted per clock when the
// result side keeps up; the parser updates its state once per byte, and a
// result is registered as the parser takes its byte from the queue. a
// two-entry queue between the front and the parser plus the result register
// absorb stalls on either side.
module notification_attribute_deframer (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  nad_pkg::in_item_t  item,
    output logic               result_valid,
    input  logic               result_ready,
    output nad_pkg::out_item_t result
);

    nad_pkg::queue_head_t head;
    logic                 head_pop;

    nad_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .head       (head),
        .head_pop   (head_pop)
    );

    nad_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .head_pop     (head_pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

`ifndef NO_ASSERTIONS
    a_pop_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        head_pop |-> (head.valid && (!result_valid || result_ready)))
        else $error("queue popped while result slot blocked");

    a_empty_marker: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.empty_attribute) |->
        (result.last_of_attribute && !result.byte_kept && result.attr_byte == 8'h00))
        else $error("malformed empty attribute marker");

    a_done_on_message: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.notification_done) |->
        (result.last_of_attribute && result.present_mask[3]
         && result.attr_id == nad_pkg::ATTR_MESSAGE))
        else $error("completion flagged outside message attribute end");
`endif

endmodule
